>>> rtl/core/contiguous_chunk_allocator_macros.svh
// Assertion macros shared by the chunk allocator RTL.
`ifndef CONTIGUOUS_CHUNK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_CHUNK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CCA_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CCA_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/cca_pkg.sv
// Shared types and constants of the contiguous chunk allocator.
package cca_pkg;

    localparam int SIZE_W     = 32;
    localparam int ADDR_W     = 64;
    localparam int RSIZE_W    = 29;
    localparam int INB_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVAL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INB   = 2'd2;

    // job fields sized for the largest supported chunk count (4096)
    localparam int JOB_IDX_W   = 12;
    localparam int JOB_CNT_W   = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_REPLY,
        JOB_ALLOC,
        JOB_FREE
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic [STATUS_W-1:0]    status;
        logic [JOB_CNT_W-1:0]   need;
        logic [JOB_IDX_W-1:0]   start;
    } t_job;

endpackage

>>> rtl/core/cca_ifs.sv
// Request and response channel interfaces of the chunk allocator.
interface cca_req_if import cca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, cmd, req_size, free_addr, input ready);
    modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface cca_rsp_if import cca_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_pa;
    logic [INB_W-1:0]    alloc_ia;

    modport source (output valid, status, alloc_pa, alloc_ia, input ready);
    modport sink   (input valid, status, alloc_pa, alloc_ia, output ready);
endinterface

>>> rtl/core/cca_front.sv
// Front end: takes request items, checks arguments and builds jobs.
module cca_front import cca_pkg::*; #(
    parameter int N_CHUNKS    = 256,
    parameter int CHUNK_SHIFT = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cca_req_if.sink                            i_req,
    input  logic                               i_enable,
    input  logic [ADDR_W-1:0]                  i_base,
    input  logic [RSIZE_W-1:0]                 i_rsize,
    input  logic [$clog2(N_CHUNKS+1)-1:0]      i_count,
    input  logic                               i_full,
    output logic                               o_push,
    output t_job                               o_job
);

    localparam int NW = SIZE_W + 1 - CHUNK_SHIFT;
    localparam int EW = ADDR_W + 1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_CLASS
    } t_fstate;

    t_fstate            r_state;
    logic               r_cmd;
    logic [SIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_off;
    logic               r_borrow;
    logic [NW-1:0]      r_need;

    logic [NW-1:0]      need_c;
    logic [ADDR_W-1:0]  start_full;
    logic [EW-1:0]      end_sum;
    logic               size_zero;

    assign i_req.ready = (r_state == F_IDLE) && i_enable;
    assign o_push      = (r_state == F_CLASS) && !i_full;

    // chunks needed, rounded up
    assign need_c = NW'(r_size >> CHUNK_SHIFT) + NW'(|r_size[CHUNK_SHIFT-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_cmd   <= i_req.cmd;
                        r_size  <= i_req.req_size;
                        r_addr  <= i_req.free_addr;
                        r_state <= F_CALC;
                    end
                end
                F_CALC: begin
                    r_need              <= need_c;
                    {r_borrow, r_off}   <= {1'b0, r_addr} - {1'b0, i_base};
                    r_state             <= F_CLASS;
                end
                F_CLASS: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        size_zero    = (r_size == '0);
        start_full   = r_off >> CHUNK_SHIFT;
        end_sum      = EW'(start_full) + EW'(r_need);
        o_job.kind   = JOB_REPLY;
        o_job.status = ST_INVAL;
        o_job.need   = JOB_CNT_W'(r_need);
        o_job.start  = JOB_IDX_W'(start_full);
        if (r_cmd == CMD_ALLOC) begin
            if (size_zero || (r_size > SIZE_W'(i_rsize))) begin
                o_job.status = ST_INVAL;
            end else if (SIZE_W'(r_need) > SIZE_W'(i_count)) begin
                o_job.status = ST_NOSPACE;
            end else begin
                o_job.kind   = JOB_ALLOC;
                o_job.status = ST_OK;
            end
        end else begin
            if (size_zero || r_borrow || (r_off >= ADDR_W'(i_rsize)) ||
                (|r_off[CHUNK_SHIFT-1:0]) || (end_sum > EW'(i_count))) begin
                o_job.status = ST_INVAL;
            end else begin
                o_job.kind   = JOB_FREE;
                o_job.status = ST_OK;
            end
        end
    end

endmodule

>>> rtl/core/cca_queue.sv
// Short job queue between front end and back end.
`include "contiguous_chunk_allocator_macros.svh"
module cca_queue import cca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    `CCA_ASSERT_IMP(a_no_push_full, i_push, !o_full, "job pushed into a full queue")
    `CCA_ASSERT_IMP(a_no_pop_empty, i_pop, o_valid, "job popped from an empty queue")
    `CCA_ASSERT_NXT(a_push_lands, i_push && !i_pop, o_valid, "pushed job not visible")

endmodule

>>> rtl/core/cca_back.sv
// Back end: bitmap memory, first-fit scan, run marking and result register.
`include "contiguous_chunk_allocator_macros.svh"
module cca_back import cca_pkg::*; #(
    parameter int N_CHUNKS    = 256,
    parameter int CHUNK_SHIFT = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  t_job                               i_job,
    output logic                               o_pop,
    input  logic [ADDR_W-1:0]                  i_base,
    input  logic [INB_W-1:0]                   i_inb,
    input  logic [$clog2(N_CHUNKS+1)-1:0]      i_count,
    output logic                               o_init_done,
    cca_rsp_if.source                          o_rsp
);

    localparam int CW = $clog2(N_CHUNKS + 1);
    localparam int IW = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_WRITE,
        B_ADDR
    } t_bstate;

    t_bstate                r_state;
    logic                   r_map [N_CHUNKS];
    logic                   r_rd_data;
    logic [CW-1:0]          r_rd_idx;
    logic [CW-1:0]          r_chk_idx;
    logic                   r_chk_valid;
    logic [CW-1:0]          r_run;
    logic [CW-1:0]          r_need;
    logic [CW-1:0]          r_left;
    logic [IW-1:0]          r_wr_idx;
    logic                   r_wr_val;
    logic                   r_is_alloc;
    logic [IW-1:0]          r_start;

    logic                   r_rsp_valid;
    logic [STATUS_W-1:0]    r_rsp_status;
    logic [ADDR_W-1:0]      r_rsp_phys;
    logic [INB_W-1:0]       r_rsp_inb;

    logic                   mem_we;
    logic [CW-1:0]          run_n;
    logic [CW-1:0]          found;
    logic [ADDR_W-1:0]      chunk_off;

    assign o_init_done = (r_state != B_CLEAR);
    assign o_pop       = (r_state == B_IDLE) && i_job_valid && !r_rsp_valid;
    assign mem_we      = (r_state == B_CLEAR) || (r_state == B_WRITE);
    assign run_n       = r_rd_data ? '0 : r_run + CW'(1);
    assign found       = r_chk_idx + CW'(1) - r_need;
    assign chunk_off   = ADDR_W'(r_start) << CHUNK_SHIFT;

    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.status   = r_rsp_status;
    assign o_rsp.alloc_pa = r_rsp_phys;
    assign o_rsp.alloc_ia = r_rsp_inb;

    // bitmap: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_wr_idx] <= r_wr_val;
        end
        r_rd_data <= r_map[r_rd_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_wr_idx    <= '0;
            r_wr_val    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_wr_idx <= r_wr_idx + IW'(1);
                    if (r_wr_idx == IW'(N_CHUNKS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_need     <= i_job.need[CW-1:0];
                        r_left     <= i_job.need[CW-1:0];
                        r_wr_idx   <= i_job.start[IW-1:0];
                        r_is_alloc <= (i_job.kind == JOB_ALLOC);
                        r_wr_val   <= (i_job.kind == JOB_ALLOC);
                        unique case (i_job.kind)
                            JOB_ALLOC: begin
                                r_rd_idx    <= '0;
                                r_chk_valid <= 1'b0;
                                r_run       <= '0;
                                r_state     <= B_SCAN;
                            end
                            JOB_FREE: begin
                                r_state <= B_WRITE;
                            end
                            default: begin
                                r_rsp_valid  <= 1'b1;
                                r_rsp_status <= i_job.status;
                                r_rsp_phys   <= '0;
                                r_rsp_inb    <= '0;
                            end
                        endcase
                    end
                end
                B_SCAN: begin
                    r_rd_idx    <= r_rd_idx + CW'(1);
                    r_chk_idx   <= r_rd_idx;
                    r_chk_valid <= 1'b1;
                    if (r_chk_valid) begin
                        r_run <= run_n;
                        if (run_n == r_need) begin
                            r_start  <= IW'(found);
                            r_wr_idx <= IW'(found);
                            r_state  <= B_WRITE;
                        end else if (r_chk_idx + CW'(1) == i_count) begin
                            r_rsp_valid  <= 1'b1;
                            r_rsp_status <= ST_NOSPACE;
                            r_rsp_phys   <= '0;
                            r_rsp_inb    <= '0;
                            r_state      <= B_IDLE;
                        end
                    end
                end
                B_WRITE: begin
                    r_wr_idx <= r_wr_idx + IW'(1);
                    r_left   <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        if (r_is_alloc) begin
                            r_state <= B_ADDR;
                        end else begin
                            r_rsp_valid  <= 1'b1;
                            r_rsp_status <= ST_OK;
                            r_rsp_phys   <= '0;
                            r_rsp_inb    <= '0;
                            r_state      <= B_IDLE;
                        end
                    end
                end
                B_ADDR: begin
                    r_rsp_valid  <= 1'b1;
                    r_rsp_status <= ST_OK;
                    r_rsp_phys   <= i_base + chunk_off;
                    r_rsp_inb    <= i_inb + chunk_off[INB_W-1:0];
                    r_state      <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `CCA_ASSERT_IMP(a_run_short, (r_state == B_SCAN) && r_chk_valid, r_run < r_need, "missed hit")
    `CCA_ASSERT_IMP(a_wr_range, r_state == B_WRITE, CW'(r_wr_idx) < i_count, "write past end")
    `CCA_ASSERT_IMP(a_pop_room, o_pop, !r_rsp_valid, "result slot busy")

endmodule

>>> rtl/core/contiguous_chunk_allocator.sv
// Top level of the first-fit contiguous chunk allocator.
//
//  channel    dir  handshake            payload
//  i_req      in   valid/ready          cmd, req_size, free_addr
//  o_rsp      out  valid/ready          status, alloc_pa, alloc_ia
//  i_cfg_*    in   i_cfg_we, no stall   i_cfg_idx, i_cfg_wdata
//
//  Front end takes one item at a time (capture, offset subtract, classify).
//  Allocate: first-fit scan reads one bitmap bit per cycle through the single
//  memory read port until the first fitting run or the last usable chunk,
//  then marks the run chunk by chunk and adds the address. Free: clears the
//  run chunk by chunk. Rejected items return without touching the bitmap.
//  After reset the bitmap is cleared before i_req.ready rises; configuration
//  writes are taken during that pass.
//  A stalled o_rsp holds the result; the front end keeps taking items into
//  a 2-entry job queue until it fills.
module contiguous_chunk_allocator import cca_pkg::*; #(
    parameter int N_CHUNKS    = 256,
    parameter int CHUNK_SHIFT = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    cca_req_if.sink                 i_req,
    cca_rsp_if.source               o_rsp,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int CW = $clog2(N_CHUNKS + 1);

    // configuration registers
    logic [ADDR_W-1:0]   r_base;
    logic [RSIZE_W-1:0]  r_rsize;
    logic [INB_W-1:0]    r_inb;
    logic [CW-1:0]       r_count;     // usable chunks, capped at N_CHUNKS

    logic [RSIZE_W-1:0]  cfg_chunks;

    // front/back plumbing
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    t_job   job_in;
    t_job   job_out;
    logic   init_done;

    assign cfg_chunks = i_cfg_wdata[RSIZE_W-1:0] >> CHUNK_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_rsize <= '0;
            r_inb   <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE: r_base <= i_cfg_wdata;
                CFG_RSIZE: begin
                    r_rsize <= i_cfg_wdata[RSIZE_W-1:0];
                    r_count <= (cfg_chunks > RSIZE_W'(N_CHUNKS)) ?
                               CW'(N_CHUNKS) : CW'(cfg_chunks);
                end
                CFG_INB: r_inb <= i_cfg_wdata[INB_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    cca_front #(
        .N_CHUNKS    (N_CHUNKS),
        .CHUNK_SHIFT (CHUNK_SHIFT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_enable (init_done),
        .i_base   (r_base),
        .i_rsize  (r_rsize),
        .i_count  (r_count),
        .i_full   (q_full),
        .o_push   (push),
        .o_job    (job_in)
    );

    cca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    cca_back #(
        .N_CHUNKS    (N_CHUNKS),
        .CHUNK_SHIFT (CHUNK_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .i_base      (r_base),
        .i_inb       (r_inb),
        .i_count     (r_count),
        .o_init_done (init_done),
        .o_rsp       (o_rsp)
    );

endmodule
